// ===== rtl/sfd_pkg.sv =====
// Shared constants and controller/datapath interface types for the serial frame deframer.
package sfd_pkg;

    localparam int MAX_FRAME_DEF         = 64;
    localparam int WORD_COUNT_DEF        = 19;
    localparam int FIRST_WORD_OFFSET_DEF = 4;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    // The type byte sits right after the two header bytes and the length byte.
    localparam int TYPE_OFFSET = 3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    typedef struct packed {
        logic sum_load;     // first header byte: sum = byte, position = 1
        logic sum_clr;      // no header: sum and position to zero
        logic accum;        // add byte to sum, advance position
        logic wr;           // write the byte into the frame store
        logic len_load;     // capture the length byte
        logic chk_load;     // compare the checksum byte with the sum
        logic rd_init;      // point the reader at the first payload byte
        logic rd_type;      // read the type byte
        logic rd_word;      // read the next payload byte
        logic type_cap;     // capture the type byte from the read port
        logic hi_cap;       // capture the high payload byte
        logic out_word;     // load a good word into the result register
        logic out_err_chk;  // load a checksum error result
        logic out_err_len;  // load a length error result
    } sfd_cmd_t;

    typedef struct packed {
        logic hdr1;         // byte is the first header byte
        logic hdr2;         // byte is the second header byte
        logic len_bad;      // byte is not a usable frame length
        logic body_last;    // the current body byte is the checksum byte
        logic chk_bad;      // the stored checksum did not match
        logic res_fire;     // the result word is taken this cycle
        logic res_last;     // the held result word closes the frame
    } sfd_sts_t;

endpackage

// ===== rtl/sfd_ctrl.sv =====
// Controller state machine for the serial frame deframer.
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rx_valid,
    output logic     rx_stall,
    input  sfd_sts_t sts,
    output sfd_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_HUNT1 = 10'b00_0000_0001,
        S_HUNT2 = 10'b00_0000_0010,
        S_LEN   = 10'b00_0000_0100,
        S_BODY  = 10'b00_0000_1000,
        S_RTYPE = 10'b00_0001_0000,
        S_TYPE  = 10'b00_0010_0000,
        S_RHI   = 10'b00_0100_0000,
        S_RLO   = 10'b00_1000_0000,
        S_LOAD  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rx_fire;

    assign rx_stall = !((state_reg == S_HUNT1) || (state_reg == S_HUNT2) ||
                        (state_reg == S_LEN) || (state_reg == S_BODY));
    assign rx_fire  = rx_valid && !rx_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_HUNT1:
            begin
                if (rx_fire)
                begin
                    if (sts.hdr1)
                    begin
                        cmd.sum_load = 1'b1;
                        cmd.wr       = 1'b1;
                        state_next   = S_HUNT2;
                    end
                    else
                    begin
                        cmd.sum_clr = 1'b1;
                    end
                end
            end
            S_HUNT2:
            begin
                if (rx_fire)
                begin
                    if (sts.hdr2)
                    begin
                        cmd.wr     = 1'b1;
                        cmd.accum  = 1'b1;
                        state_next = S_LEN;
                    end
                    else
                    begin
                        state_next = S_HUNT1;
                    end
                end
            end
            S_LEN:
            begin
                if (rx_fire)
                begin
                    if (sts.len_bad)
                    begin
                        cmd.out_err_len = 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        cmd.wr       = 1'b1;
                        cmd.accum    = 1'b1;
                        cmd.len_load = 1'b1;
                        state_next   = S_BODY;
                    end
                end
            end
            S_BODY:
            begin
                if (rx_fire)
                begin
                    cmd.wr = 1'b1;
                    if (sts.body_last)
                    begin
                        cmd.chk_load = 1'b1;
                        cmd.rd_init  = 1'b1;
                        state_next   = S_RTYPE;
                    end
                    else
                    begin
                        cmd.accum = 1'b1;
                    end
                end
            end
            S_RTYPE:
            begin
                cmd.rd_type = 1'b1;
                state_next  = S_TYPE;
            end
            S_TYPE:
            begin
                cmd.type_cap = 1'b1;
                if (sts.chk_bad)
                begin
                    cmd.out_err_chk = 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    cmd.rd_word = 1'b1;
                    state_next  = S_RLO;
                end
            end
            S_RHI:
            begin
                cmd.rd_word = 1'b1;
                state_next  = S_RLO;
            end
            S_RLO:
            begin
                cmd.hi_cap  = 1'b1;
                cmd.rd_word = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.out_word = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (sts.res_fire)
                begin
                    state_next = sts.res_last ? S_HUNT1 : S_RHI;
                end
            end
            default:
            begin
                state_next = S_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sfd_dp.sv =====
// Datapath of the serial frame deframer: frame store, sum, read pointer and result register.
module sfd_dp
    import sfd_pkg::*;
#(
    parameter int MAX_FRAME         = MAX_FRAME_DEF,
    parameter int WORD_COUNT        = WORD_COUNT_DEF,
    parameter int FIRST_WORD_OFFSET = FIRST_WORD_OFFSET_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  sfd_cmd_t           cmd,
    output sfd_sts_t           sts,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         status,
    output logic [7:0]         msg_type,
    output logic [4:0]         word_index,
    output logic signed [15:0] word_value,
    output logic               last
);

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam logic [8:0] MIN_LEN = 9'(FIRST_WORD_OFFSET + 2 * WORD_COUNT + 1);
    localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME);
    localparam logic [4:0] LAST_IDX = 5'(WORD_COUNT - 1);

    logic [7:0]    mem [MAX_FRAME];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    logic [7:0]    sum_reg;
    logic [7:0]    pos_reg;
    logic [7:0]    len_reg;
    logic          chk_bad_reg;
    logic [AW-1:0] ptr_reg;
    logic [4:0]    idx_reg;
    logic [7:0]    type_reg;
    logic [7:0]    hi_reg;

    logic          res_valid_reg;
    logic [1:0]    status_reg;
    logic [7:0]    type_out_reg;
    logic [4:0]    index_reg;
    logic [15:0]   value_reg;
    logic          last_reg;
    logic          res_fire;

    assign res_fire = res_valid_reg && !res_stall;

    assign sts.hdr1      = (rx_byte == HDR_FIRST);
    assign sts.hdr2      = (rx_byte == HDR_SECOND);
    assign sts.len_bad   = ({1'b0, rx_byte} < MIN_LEN) || ({1'b0, rx_byte} > MAX_LEN);
    assign sts.body_last = (({1'b0, pos_reg} + 9'd1) >= {1'b0, len_reg});
    assign sts.chk_bad   = chk_bad_reg;
    assign sts.res_fire  = res_fire;
    assign sts.res_last  = last_reg;

    // The first header byte always lands at offset zero, whatever the position says.
    assign wr_addr = cmd.sum_load ? '0 : pos_reg[AW-1:0];
    assign rd_addr = cmd.rd_type ? AW'(TYPE_OFFSET) : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd_type || cmd.rd_word)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            pos_reg       <= '0;
            len_reg       <= '0;
            chk_bad_reg   <= 1'b0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sum_load)
            begin
                sum_reg <= rx_byte;
                pos_reg <= 8'd1;
            end
            else if (cmd.sum_clr)
            begin
                sum_reg <= '0;
                pos_reg <= '0;
            end
            else if (cmd.accum)
            begin
                sum_reg <= sum_reg + rx_byte;
                pos_reg <= pos_reg + 8'd1;
            end
            if (cmd.len_load)
            begin
                len_reg <= rx_byte;
            end
            if (cmd.chk_load)
            begin
                chk_bad_reg <= (rx_byte != sum_reg);
            end
            if (cmd.rd_init)
            begin
                ptr_reg <= AW'(FIRST_WORD_OFFSET);
                idx_reg <= '0;
            end
            else
            begin
                if (cmd.rd_word)
                begin
                    ptr_reg <= ptr_reg + AW'(1);
                end
                if (cmd.out_word)
                begin
                    idx_reg <= idx_reg + 5'd1;
                end
            end
            if (cmd.out_word || cmd.out_err_chk || cmd.out_err_len)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_fire)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.type_cap)
        begin
            type_reg <= rd_data_reg;
        end
        if (cmd.hi_cap)
        begin
            hi_reg <= rd_data_reg;
        end
        if (cmd.out_word)
        begin
            status_reg   <= STATUS_OK;
            type_out_reg <= type_reg;
            index_reg    <= idx_reg;
            value_reg    <= {hi_reg, rd_data_reg};
            last_reg     <= (idx_reg == LAST_IDX);
        end
        else if (cmd.out_err_chk)
        begin
            // The type byte is captured in the same cycle, so take it from the read port.
            status_reg   <= STATUS_BAD_SUM;
            type_out_reg <= rd_data_reg;
            index_reg    <= '0;
            value_reg    <= '0;
            last_reg     <= 1'b1;
        end
        else if (cmd.out_err_len)
        begin
            status_reg   <= STATUS_BAD_LEN;
            type_out_reg <= '0;
            index_reg    <= '0;
            value_reg    <= '0;
            last_reg     <= 1'b1;
        end
    end

    assign res_valid  = res_valid_reg;
    assign status     = status_reg;
    assign msg_type   = type_out_reg;
    assign word_index = index_reg;
    assign word_value = value_reg;
    assign last       = last_reg;

endmodule

// ===== rtl/serial_frame_deframer_sum8_unit.sv =====
// Top level of the serial frame deframer with 8-bit additive checksum.
//
// Channel   Direction  Handshake            Word
// rx        in         rx_valid/rx_stall    rx_byte
// res       out        res_valid/res_stall  status, msg_type, word_index, word_value, last
//
// Header, length and body bytes are taken while rx_stall is low. After the checksum byte
// the type byte is read, then each payload word takes two frame store reads and the result
// load, and is held on offer until taken. A checksum error result is loaded once the type
// byte is read, a length error result as its length byte is taken. rx_stall is high from
// the cycle after such a byte until the cycle after the last result is taken. Reset
// returns the block to the header hunt; the store is not cleared.
module serial_frame_deframer_sum8_unit
    import sfd_pkg::*;
#(
    parameter int MAX_FRAME         = MAX_FRAME_DEF,
    parameter int WORD_COUNT        = WORD_COUNT_DEF,
    parameter int FIRST_WORD_OFFSET = FIRST_WORD_OFFSET_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         status,
    output logic [7:0]         msg_type,
    output logic [4:0]         word_index,
    output logic signed [15:0] word_value,
    output logic               last
);

    sfd_cmd_t cmd;
    sfd_sts_t sts;

    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfd_dp #(
        .MAX_FRAME         (MAX_FRAME),
        .WORD_COUNT        (WORD_COUNT),
        .FIRST_WORD_OFFSET (FIRST_WORD_OFFSET)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .msg_type   (msg_type),
        .word_index (word_index),
        .word_value (word_value),
        .last       (last)
    );

endmodule
